### rtl/wms_pkg.sv
// wiper mode sequencer package: mode and command codes, register indexes, field widths
// no dependencies; used by wiper_mode_sequencer_top

package wms_pkg;

  // field and port widths
  localparam int unsigned CFG_DATA_W  = 16;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned MODE_W      = 3;
  localparam int unsigned CMD_W       = 2;
  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned OUT_TDATA_W = 8;
  localparam int unsigned COUNT_BITS_DEF = 16;

  // request kinds carried in tuser
  localparam logic REQ_TICK = 1'b0;
  localparam logic REQ_SET  = 1'b1;

  // wiper modes
  typedef enum logic [MODE_W-1:0] {
    MODE_OFF    = 3'd0,
    MODE_LOW    = 3'd1,
    MODE_HIGH   = 3'd2,
    MODE_AUTO   = 3'd3,
    MODE_WASH   = 3'd4,
    MODE_REPAIR = 3'd5,
    MODE_IDLE   = 3'd6
  } mode_e;

  // motor commands
  typedef enum logic [CMD_W-1:0] {
    CMD_OFF  = 2'd0,
    CMD_LOW  = 2'd1,
    CMD_HIGH = 2'd2
  } cmd_e;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PARK_HOLD    = 3'd0,
    REG_WASH_FIRST   = 3'd1,
    REG_WASH_PAUSE   = 3'd2,
    REG_WASH_SECOND  = 3'd3,
    REG_REPAIR_TICKS = 3'd4
  } reg_idx_e;

endpackage

### rtl/wiper_mode_sequencer_top.sv
// wiper mode sequencer: mode register, per-mode counters and one result register
// depends on wms_pkg
//
// channel    dir   tdata (low bit up)                          tuser
// s_axis     in    new_mode[2:0] park_level park_rise pad[7:5]  req_type
// m_axis     out   drive_valid drive_cmd[1:0] mode_now[2:0] pad  -
// cfg        in    cfg_idx_i selects register, cfg_data_i value  -
//
// one transaction per cycle; each result shows in the cycle after its input
// transaction. all next-state and result logic is one pass of compares and
// increments on the counters. reset puts the mode to idle and clears every
// counter and register. a stalled result holds in the output register and
// the input side stops only while that register is full and not taken.

module wiper_mode_sequencer_top #(
  parameter int unsigned COUNT_BITS = wms_pkg::COUNT_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration write port
  input  logic                              cfg_we_i,
  input  logic [wms_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [wms_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  // input stream
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [wms_pkg::IN_TDATA_W-1:0]    s_axis_tdata,  // new_mode, park_level, park_rise
  input  logic                              s_axis_tuser,  // req_type
  // result stream
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [wms_pkg::OUT_TDATA_W-1:0]   m_axis_tdata   // drive_valid, drive_cmd, mode_now
);

  import wms_pkg::*;

  localparam int unsigned CMP_W  = (COUNT_BITS > CFG_DATA_W) ? COUNT_BITS : CFG_DATA_W;
  localparam int unsigned OPAD_W = OUT_TDATA_W - 1 - CMD_W - MODE_W;
  localparam logic [COUNT_BITS-1:0] CntOne = COUNT_BITS'(1);

  typedef logic [COUNT_BITS-1:0] cnt_t;
  typedef logic [CMP_W-1:0]      cmp_t;

  // configuration registers
  logic [CFG_DATA_W-1:0] park_hold_q, wash_first_q, wash_pause_q, wash_second_q, repair_ticks_q;

  // state
  mode_e mode_q, mode_d;
  cnt_t  park_cnt_q, park_cnt_d;
  cnt_t  first_cnt_q, first_cnt_d;
  cnt_t  pause_cnt_q, pause_cnt_d;
  cnt_t  second_cnt_q, second_cnt_d;
  cnt_t  repair_cnt_q, repair_cnt_d;

  // result register
  logic                   out_valid_q;
  logic [OUT_TDATA_W-1:0] out_data_q;

  logic                   in_acc;
  logic [MODE_W-1:0]      in_mode;
  logic                   in_level;
  logic                   in_rise;
  logic                   drv_valid;
  cmd_e                   drv_cmd;

  assign in_mode  = s_axis_tdata[MODE_W-1:0];
  assign in_level = s_axis_tdata[MODE_W];
  assign in_rise  = s_axis_tdata[MODE_W+1];

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      park_hold_q    <= '0;
      wash_first_q   <= '0;
      wash_pause_q   <= '0;
      wash_second_q  <= '0;
      repair_ticks_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_PARK_HOLD:    park_hold_q    <= cfg_data_i;
        REG_WASH_FIRST:   wash_first_q   <= cfg_data_i;
        REG_WASH_PAUSE:   wash_pause_q   <= cfg_data_i;
        REG_WASH_SECOND:  wash_second_q  <= cfg_data_i;
        REG_REPAIR_TICKS: repair_ticks_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // next mode, counters and drive command for one transaction
  always_comb begin
    cnt_t first_new;
    cnt_t pause_new;
    cnt_t second_new;

    mode_d       = mode_q;
    park_cnt_d   = park_cnt_q;
    first_cnt_d  = first_cnt_q;
    pause_cnt_d  = pause_cnt_q;
    second_cnt_d = second_cnt_q;
    repair_cnt_d = repair_cnt_q;
    drv_valid    = 1'b0;
    drv_cmd      = CMD_OFF;
    first_new    = in_rise ? (first_cnt_q + CntOne) : first_cnt_q;
    pause_new    = pause_cnt_q + CntOne;
    second_new   = in_rise ? (second_cnt_q + CntOne) : second_cnt_q;

    if (s_axis_tuser == REQ_SET) begin
      // code seven is dropped
      if (in_mode <= MODE_W'(MODE_IDLE)) begin
        mode_d = mode_e'(in_mode);
      end
    end else begin
      // counters of the other modes are cleared on a tick
      if (mode_q != MODE_OFF) begin
        park_cnt_d = '0;
      end
      if (mode_q != MODE_WASH) begin
        first_cnt_d  = '0;
        pause_cnt_d  = '0;
        second_cnt_d = '0;
      end
      if (mode_q != MODE_REPAIR) begin
        repair_cnt_d = '0;
      end

      unique case (mode_q)
        MODE_OFF: begin
          if (cmp_t'(park_cnt_q) < cmp_t'(park_hold_q)) begin
            if (in_level) begin
              park_cnt_d = park_cnt_q + CntOne;
            end else begin
              park_cnt_d = '0;
              drv_valid  = 1'b1;
              drv_cmd    = CMD_LOW;
            end
          end else if (cmp_t'(park_cnt_q) == cmp_t'(park_hold_q)) begin
            drv_valid = 1'b1;
            drv_cmd   = CMD_OFF;
            mode_d    = MODE_IDLE;
          end
        end
        MODE_LOW: begin
          drv_valid = 1'b1;
          drv_cmd   = CMD_LOW;
        end
        MODE_HIGH: begin
          drv_valid = 1'b1;
          drv_cmd   = CMD_HIGH;
        end
        MODE_WASH: begin
          if (cmp_t'(first_cnt_q) < cmp_t'(wash_first_q)) begin
            // first sweep phase
            first_cnt_d = first_new;
            if (!in_rise) begin
              drv_valid = 1'b1;
              drv_cmd   = CMD_LOW;
            end
            if (cmp_t'(first_new) == cmp_t'(wash_first_q)) begin
              drv_valid = 1'b1;
              drv_cmd   = CMD_OFF;
            end
          end else if (cmp_t'(first_cnt_q) == cmp_t'(wash_first_q) &&
                       cmp_t'(pause_cnt_q) < cmp_t'(wash_pause_q)) begin
            // pause phase
            pause_cnt_d = pause_new;
            if (cmp_t'(pause_new) == cmp_t'(wash_pause_q)) begin
              drv_valid = 1'b1;
              drv_cmd   = CMD_LOW;
            end
          end else if (cmp_t'(pause_cnt_q) == cmp_t'(wash_pause_q) &&
                       cmp_t'(second_cnt_q) < cmp_t'(wash_second_q)) begin
            // second sweep phase
            second_cnt_d = second_new;
            if (cmp_t'(second_new) == cmp_t'(wash_second_q)) begin
              mode_d = MODE_OFF;
            end
          end
        end
        MODE_REPAIR: begin
          drv_valid = 1'b1;
          if (cmp_t'(repair_cnt_q) < cmp_t'(repair_ticks_q)) begin
            repair_cnt_d = repair_cnt_q + CntOne;
            drv_cmd      = CMD_LOW;
          end else begin
            drv_cmd = CMD_OFF;
            mode_d  = MODE_IDLE;
          end
        end
        default: ;
      endcase
    end
  end

  // state and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= MODE_IDLE;
      park_cnt_q   <= '0;
      first_cnt_q  <= '0;
      pause_cnt_q  <= '0;
      second_cnt_q <= '0;
      repair_cnt_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (in_acc) begin
        mode_q       <= mode_d;
        park_cnt_q   <= park_cnt_d;
        first_cnt_q  <= first_cnt_d;
        pause_cnt_q  <= pause_cnt_d;
        second_cnt_q <= second_cnt_d;
        repair_cnt_q <= repair_cnt_d;
        out_valid_q  <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q  <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_data_q <= '0;
    end else if (in_acc) begin
      out_data_q <= {{OPAD_W{1'b0}}, mode_d, drv_cmd, drv_valid};
    end
  end

`ifndef SYNTHESIS
  // a nonzero command is only reported with drive_valid set
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[0] || m_axis_tdata[CMD_W:1] == CMD_OFF))
    else $error("drive_cmd set without drive_valid");

  // every accepted transaction lands in the result register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> out_valid_q)
    else $error("accepted transaction lost its result");

  // a tick outside repair leaves the repair counter cleared
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && s_axis_tuser == REQ_TICK && mode_q != MODE_REPAIR) |=> repair_cnt_q == '0)
    else $error("repair counter not cleared");

  // a tick outside wash leaves all wash counters cleared
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && s_axis_tuser == REQ_TICK && mode_q != MODE_WASH) |=>
      (first_cnt_q == '0 && pause_cnt_q == '0 && second_cnt_q == '0))
    else $error("wash counters not cleared");
`endif

endmodule
